// File: design/rc5_pkg.sv
// Shared types and constants for the RC5/RC5X wired frame transmitter.
// Used by the front queue, the back engine and the top level.
package rc5_pkg;

  localparam int FRAME_W = 20;
  localparam int PLAIN_LEN = 14;
  localparam int EXT_LEN = 20;
  localparam int PAUSE_AFTER_BIT = 12;
  localparam int TOGGLE_POS_EXT = 17;
  localparam int TOGGLE_POS_PLAIN = 11;

  localparam logic [15:0] HALF_BIT_RESET = 16'd889;
  localparam logic [17:0] PAUSE_RESET = 18'd3556;
  localparam logic [19:0] GAP_RESET = 20'd89000;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  typedef enum logic [1:0] {
    CFG_HALF_BIT = 2'd0,
    CFG_PAUSE    = 2'd1,
    CFG_GAP      = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BITS  = 2'd1,
    PH_PAUSE = 2'd2,
    PH_GAP   = 2'd3
  } phase_t;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [4:0] bit_idx_t;

  typedef struct packed {
    logic [15:0] half_bit_ticks;
    logic [17:0] pause_ticks;
    logic [19:0] gap_ticks;
  } cfg_regs_t;

  // One classified transaction waiting for the back engine. The frame has its
  // toggle bit clear; the engine inserts the kept toggle when it takes it.
  typedef struct packed {
    logic       is_send;
    logic       ext;
    frame_t     frame;
    logic [7:0] reps;
  } q_entry_t;

endpackage

// File: design/rc5_front.sv
// Front part: accepts input transactions, classifies them and builds the
// frame word, then holds them in a two-entry queue. Depends on rc5_pkg.
module rc5_front
  import rc5_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic       operation,
  input  logic [4:0] address,
  input  logic [6:0] command,
  input  logic [5:0] extension,
  input  logic       extended,
  input  logic [7:0] repeat_count,
  output logic       q_valid,
  input  logic       q_ready,
  output q_entry_t   q_data
);

  localparam int QDEPTH = 2;
  localparam int PW = $clog2(QDEPTH);

  q_entry_t        entries [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  q_entry_t        entry_in;
  logic            push;
  logic            pop;

  always_comb begin
    entry_in.is_send = (operation == OP_SEND);
    entry_in.ext = extended;
    entry_in.reps = repeat_count;
    if (extended) begin
      // S2 carries the inverted command bit 6 in an extended frame.
      entry_in.frame = {1'b1, ~command[6], 1'b0, address, command[5:0], extension};
    end else begin
      entry_in.frame = {6'd0, 1'b1, 1'b1, 1'b0, address, command[5:0]};
    end
  end

  assign item_ready = (count != (PW + 1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_data = entries[rd_ptr];
  assign push = item_valid && item_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= entry_in;
    end
  end

  // Pointers wrap naturally because the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/rc5_back.sv
// Back part: serializer and timer engine running one queued transaction per cycle
// unless a held result stalls it, plus the result register. Depends on rc5_pkg.
module rc5_back
  import rc5_pkg::*;
#(
  parameter int TIMER_WIDTH = 20
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg,
  input  logic      q_valid,
  output logic      q_ready,
  input  q_entry_t  q_data,
  output logic      result_valid,
  input  logic      result_ready,
  output logic      line_level,
  output logic      busy_res,
  output logic      accepted
);

  typedef logic [TIMER_WIDTH-1:0] tmr_t;

  localparam int WW = (TIMER_WIDTH > FRAME_W) ? TIMER_WIDTH : FRAME_W;
  localparam logic [WW-1:0] TMAX = WW'({TIMER_WIDTH{1'b1}});

  frame_t     frame_shift, frame_shift_next;
  bit_idx_t   bit_index, bit_index_next;
  logic       second_half, second_half_next;
  tmr_t       tick_count, tick_count_next;
  phase_t     phase, phase_next;
  logic [7:0] repeats_left, repeats_left_next;
  logic       toggle_state, toggle_state_next;
  logic       frame_is_ext, frame_is_ext_next;
  logic       line_reg, line_reg_next;

  logic       take;
  logic       acc_now;
  tmr_t       half_load;
  tmr_t       pause_load;
  tmr_t       gap_load;
  logic [WW-1:0] pause_w;
  logic [WW-1:0] gap_w;
  logic [15:0] half_raw;

  assign take = q_valid && (!result_valid || result_ready);
  assign q_ready = !result_valid || result_ready;

  // Segment lengths: pause and gap are saturated to the timer width; a zero half-bit length becomes one.
  always_comb begin
    half_raw = (cfg.half_bit_ticks == 16'd0) ? 16'd1 : cfg.half_bit_ticks;
    half_load = tmr_t'(half_raw);
    pause_w = WW'(cfg.pause_ticks);
    gap_w = WW'(cfg.gap_ticks);
    pause_load = (pause_w > TMAX) ? tmr_t'(TMAX) : tmr_t'(pause_w);
    gap_load = (gap_w > TMAX) ? tmr_t'(TMAX) : tmr_t'(gap_w);
  end

  // Next state. One segment end can ripple through the end of a frame, an
  // empty gap and the start of the next repeat in the same transaction.
  always_comb begin
    logic do_next_bit;
    logic do_end_frame;
    logic do_end_gap;
    logic do_start;
    tmr_t dec;

    frame_shift_next = frame_shift;
    bit_index_next = bit_index;
    second_half_next = second_half;
    tick_count_next = tick_count;
    phase_next = phase;
    repeats_left_next = repeats_left;
    toggle_state_next = toggle_state;
    frame_is_ext_next = frame_is_ext;
    line_reg_next = line_reg;
    acc_now = 1'b0;
    do_next_bit = 1'b0;
    do_end_frame = 1'b0;
    do_end_gap = 1'b0;
    do_start = 1'b0;
    dec = tick_count - 1'b1;

    if (take) begin
      if (!q_data.is_send) begin
        if (phase != PH_IDLE) begin
          tick_count_next = dec;
          if (dec == '0) begin
            unique case (phase)
              PH_BITS: begin
                if (!second_half) begin
                  second_half_next = 1'b1;
                  line_reg_next = frame_shift[bit_index];
                  tick_count_next = half_load;
                end else if (frame_is_ext &&
                             bit_index == bit_idx_t'(PAUSE_AFTER_BIT) &&
                             cfg.pause_ticks != '0) begin
                  phase_next = PH_PAUSE;
                  tick_count_next = pause_load;
                end else begin
                  do_next_bit = 1'b1;
                end
              end
              PH_PAUSE: do_next_bit = 1'b1;
              PH_GAP:   do_end_gap = 1'b1;
              default:  ;
            endcase
          end
        end
      end else if (phase == PH_IDLE) begin
        acc_now = 1'b1;
        toggle_state_next = ~toggle_state;
        frame_is_ext_next = q_data.ext;
        frame_shift_next = q_data.frame;
        if (q_data.ext) begin
          frame_shift_next[TOGGLE_POS_EXT] = ~toggle_state;
        end else begin
          frame_shift_next[TOGGLE_POS_PLAIN] = ~toggle_state;
        end
        repeats_left_next = q_data.reps;
        do_start = (q_data.reps != 8'd0);
      end
    end

    if (do_next_bit) begin
      if (bit_index == '0) begin
        do_end_frame = 1'b1;
      end else begin
        bit_index_next = bit_index - 1'b1;
        second_half_next = 1'b0;
        line_reg_next = ~frame_shift[bit_index - 1'b1];
        tick_count_next = half_load;
        phase_next = PH_BITS;
      end
    end

    if (do_end_frame) begin
      line_reg_next = 1'b0;
      phase_next = PH_GAP;
      tick_count_next = gap_load;
      if (gap_load == '0) begin
        do_end_gap = 1'b1;
      end
    end

    if (do_end_gap) begin
      repeats_left_next = repeats_left - 1'b1;
      if (repeats_left_next != 8'd0) begin
        do_start = 1'b1;
      end else begin
        phase_next = PH_IDLE;
        tick_count_next = '0;
        line_reg_next = 1'b0;
      end
    end

    if (do_start) begin
      bit_index_next = frame_is_ext_next ? bit_idx_t'(EXT_LEN - 1)
                                         : bit_idx_t'(PLAIN_LEN - 1);
      second_half_next = 1'b0;
      line_reg_next = ~frame_shift_next[bit_index_next];
      tick_count_next = half_load;
      phase_next = PH_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_shift <= '0;
      bit_index <= '0;
      second_half <= 1'b0;
      tick_count <= '0;
      phase <= PH_IDLE;
      repeats_left <= '0;
      toggle_state <= 1'b0;
      frame_is_ext <= 1'b0;
      line_reg <= 1'b0;
    end else begin
      frame_shift <= frame_shift_next;
      bit_index <= bit_index_next;
      second_half <= second_half_next;
      tick_count <= tick_count_next;
      phase <= phase_next;
      repeats_left <= repeats_left_next;
      toggle_state <= toggle_state_next;
      frame_is_ext <= frame_is_ext_next;
      line_reg <= line_reg_next;
    end
  end

  // Result register; it reports the state after the transaction's update.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      line_level <= line_reg_next;
      busy_res <= (phase_next != PH_IDLE);
      accepted <= acc_now;
    end
  end

endmodule

// File: design/rc5_wired_frame_transmitter.sv
// Top level of the RC5/RC5X wired frame transmitter: configuration registers,
// the front queue (rc5_front) and the back engine (rc5_back). Uses rc5_pkg.
//
//   Channel   Handshake                   Payload
//   item      item_valid / item_ready     operation, address, command,
//                                         extension, extended, repeat_count
//   result    result_valid / result_ready line_level, busy_res, accepted
//   cfg       cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One item per cycle is sustained while results are taken; an accepted item
// passes through a queue entry and then the result register to its result.
// The rate is set by the combined timer and serializer update.
// Reset clears control and engine state and loads the default timing registers.
// A held result stalls the engine; the two-entry queue keeps taking items
// until it is full. cfg_ready is always high.
module rc5_wired_frame_transmitter
  import rc5_pkg::*;
#(
  parameter int TIMER_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        operation,
  input  logic [4:0]  address,
  input  logic [6:0]  command,
  input  logic [5:0]  extension,
  input  logic        extended,
  input  logic [7:0]  repeat_count,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        line_level,
  output logic        busy_res,
  output logic        accepted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  cfg_regs_t cfg;
  logic      q_valid;
  logic      q_ready;
  q_entry_t  q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_bit_ticks <= HALF_BIT_RESET;
      cfg.pause_ticks <= PAUSE_RESET;
      cfg.gap_ticks <= GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HALF_BIT: cfg.half_bit_ticks <= cfg_data[15:0];
        CFG_PAUSE:    cfg.pause_ticks <= cfg_data[17:0];
        CFG_GAP:      cfg.gap_ticks <= cfg_data;
        default:      ;
      endcase
    end
  end

  rc5_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .operation    (operation),
    .address      (address),
    .command      (command),
    .extension    (extension),
    .extended     (extended),
    .repeat_count (repeat_count),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data)
  );

  rc5_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .line_level   (line_level),
    .busy_res     (busy_res),
    .accepted     (accepted)
  );

endmodule

// File: design/rc5_checker.sv
// Port-level checker for the RC5/RC5X wired frame transmitter, attached to
// the top level by the bind statement at the end. Uses only the top's ports.
module rc5_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic        line_level,
  input logic        busy_res,
  input logic        accepted
);

  logic       item_fire;
  logic       res_fire;
  logic [2:0] outstanding;
  logic       have_prev;
  logic       prev_busy;

  assign item_fire = item_valid && item_ready;
  assign res_fire = result_valid && result_ready;

  // Transactions taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (item_fire && !res_fire) begin
      outstanding <= outstanding + 1'b1;
    end else if (res_fire && !item_fire) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_busy <= 1'b0;
    end else if (res_fire) begin
      have_prev <= 1'b1;
      prev_busy <= busy_res;
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (outstanding != 3'd0))
    else $error("result shown with no transaction outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'd3)
    else $error("more transactions held than the queue and output allow");

  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !busy_res) |-> !line_level)
    else $error("line high while the transmitter is idle");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (res_fire && accepted && have_prev) |-> !prev_busy)
    else $error("send request taken while a frame was in progress");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(line_level) && $stable(busy_res) && $stable(accepted)))
    else $error("stalled result changed");

endmodule

bind rc5_wired_frame_transmitter rc5_checker u_rc5_checker (.*);
